// ----- rtl/core/nfsl_pkg.sv -----
// nfsl_pkg: types and constants for the nearest function symbol lookup
// no dependencies; used by nearest_function_symbol_lookup

package nfsl_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int VALUE_W = 64;
    localparam int TYPE_W  = 4;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [TYPE_W-1:0] FUNC_TYPE = 4'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_SYMBOL_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// ----- rtl/core/nearest_function_symbol_lookup.sv -----
// nearest_function_symbol_lookup: symbol table with nearest preceding function search
// depends on nfsl_pkg

// A load beat writes one table entry in the cycle it is accepted and gives no result.
// A query beat walks entries 0 .. min(symbol_count, TABLE_DEPTH)-1 through one shared
// subtract and compare unit, one entry per cycle, behind a registered read port of the
// table memory; a query holds the input until its result is written to the output
// register, which waits for the output to be free. The result waits there, so loads
// are taken while it is not yet collected. No clearing pass: entries must be loaded
// before a query reaches them.

module nearest_function_symbol_lookup #(
    parameter int TABLE_DEPTH = nfsl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nfsl_pkg::PADDR_W-1:0]  paddr,
    input  logic [nfsl_pkg::PDATA_W-1:0]  pwdata,
    output logic [nfsl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [nfsl_pkg::INDEX_W-1:0]  entry_index,
    input  logic [nfsl_pkg::VALUE_W-1:0]  sym_value,
    input  logic [nfsl_pkg::TYPE_W-1:0]   sym_type,
    input  logic [nfsl_pkg::VALUE_W-1:0]  query_addr,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [nfsl_pkg::INDEX_W-1:0]  match_index,
    output logic [nfsl_pkg::VALUE_W-1:0]  offset
);

    localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = nfsl_pkg::VALUE_W + nfsl_pkg::TYPE_W;

    nfsl_pkg::state_t state_reg, state_next;

    logic [nfsl_pkg::COUNT_W-1:0] count_reg;

    logic [ENTRY_W-1:0]           table_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]           rd_data_reg;

    logic [nfsl_pkg::VALUE_W-1:0] addr_reg;
    logic [CNT_W-1:0]             limit_reg;
    logic [CNT_W-1:0]             pos_reg;

    logic                         s1_vld_reg;
    logic [ADDR_W-1:0]            s1_idx_reg;
    logic                         s2_vld_reg;
    logic                         s2_cand_reg;
    logic [ADDR_W-1:0]            s2_idx_reg;
    logic [nfsl_pkg::VALUE_W-1:0] s2_diff_reg;

    logic                         best_vld_reg;
    logic [ADDR_W-1:0]            best_idx_reg;
    logic [nfsl_pkg::VALUE_W-1:0] best_dist_reg;

    logic                         out_vld_reg;
    logic                         found_reg;
    logic [nfsl_pkg::INDEX_W-1:0] match_index_reg;
    logic [nfsl_pkg::VALUE_W-1:0] offset_reg;

    logic                         cfg_wr;
    logic                         in_accept;
    logic                         load_wr;
    logic                         query_start;
    logic                         issue;
    logic                         scan_empty;
    logic                         out_free;
    logic                         out_load;
    logic [CNT_W-1:0]             limit_calc;
    logic [nfsl_pkg::VALUE_W-1:0] rd_value;
    logic [nfsl_pkg::TYPE_W-1:0]  rd_type;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[nfsl_pkg::PADDR_W-1] == nfsl_pkg::REG_SYMBOL_COUNT);
    assign prdata = (paddr[nfsl_pkg::PADDR_W-1] == nfsl_pkg::REG_SYMBOL_COUNT)
                    ? nfsl_pkg::PDATA_W'(count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            count_reg <= pwdata[nfsl_pkg::COUNT_W-1:0];
        end
    end

    // handshake and sequencing
    assign in_accept   = in_valid && !in_stall;
    assign load_wr     = in_accept && (command == nfsl_pkg::CMD_LOAD)
                         && (32'(entry_index) < 32'(TABLE_DEPTH));
    assign query_start = in_accept && (command == nfsl_pkg::CMD_QUERY);
    assign scan_empty  = !issue && !s1_vld_reg && !s2_vld_reg;
    assign out_free    = !out_vld_reg || !out_stall;
    assign limit_calc  = (32'(count_reg) > 32'(TABLE_DEPTH))
                         ? CNT_W'(TABLE_DEPTH) : CNT_W'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nfsl_pkg::ST_IDLE:
            begin
                if (query_start)
                begin
                    state_next = nfsl_pkg::ST_SCAN;
                end
            end
            nfsl_pkg::ST_SCAN:
            begin
                if (scan_empty)
                begin
                    state_next = nfsl_pkg::ST_FINISH;
                end
            end
            nfsl_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = nfsl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nfsl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        issue    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            nfsl_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            nfsl_pkg::ST_SCAN:
            begin
                issue = (pos_reg < limit_reg);
            end
            nfsl_pkg::ST_FINISH:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfsl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // symbol table
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            table_mem[ADDR_W'(entry_index)] <= {sym_value, sym_type};
        end
        rd_data_reg <= table_mem[pos_reg[ADDR_W-1:0]];
    end

    assign rd_value = rd_data_reg[ENTRY_W-1:nfsl_pkg::TYPE_W];
    assign rd_type  = rd_data_reg[nfsl_pkg::TYPE_W-1:0];

    // scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            limit_reg    <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            best_idx_reg <= '0;
            best_dist_reg <= '1;
        end
        else
        begin
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
            if (query_start)
            begin
                pos_reg       <= '0;
                limit_reg     <= limit_calc;
                best_vld_reg  <= 1'b0;
                best_idx_reg  <= '0;
                best_dist_reg <= '1;
            end
            else
            begin
                if (issue)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
                if (s2_vld_reg && s2_cand_reg
                    && (!best_vld_reg || (s2_diff_reg < best_dist_reg)))
                begin
                    best_vld_reg  <= 1'b1;
                    best_idx_reg  <= s2_idx_reg;
                    best_dist_reg <= s2_diff_reg;
                end
            end
        end
    end

    // shared subtract and compare unit
    always_ff @(posedge clk)
    begin
        if (query_start)
        begin
            addr_reg <= query_addr;
        end
        s1_idx_reg  <= pos_reg[ADDR_W-1:0];
        s2_idx_reg  <= s1_idx_reg;
        s2_cand_reg <= (rd_type == nfsl_pkg::FUNC_TYPE) && (rd_value < addr_reg);
        s2_diff_reg <= addr_reg - rd_value;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            found_reg       <= best_vld_reg;
            match_index_reg <= best_vld_reg ? nfsl_pkg::INDEX_W'(best_idx_reg) : '0;
            offset_reg      <= best_vld_reg ? best_dist_reg : '0;
        end
    end

    assign out_valid   = out_vld_reg;
    assign found       = found_reg;
    assign match_index = match_index_reg;
    assign offset      = offset_reg;

endmodule
